@@ rtl/set_assoc_cache_tag_lookup_macros.svh @@
// Assertion macros for the cache tag lookup block.
// Each macro checks a property on the rising clock edge, disabled while reset is held.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define SACTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SACTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SACTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SACTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/sactl_pkg.sv @@
package sactl_pkg;

  // Default sizes of the tag store.
  localparam int ADDR_BITS_DEF  = 15;
  localparam int NUM_LINES_DEF  = 256;
  localparam int MAX_WAYS_DEF   = 8;
  localparam int STAMP_BITS_DEF = 32;

  // Fixed widths of the beat fields and the configuration port.
  localparam int ADDRESS_W  = 15;
  localparam int SET_NUM_W  = 8;
  localparam int WAY_USED_W = 3;
  localparam int HITS_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Access kinds and replacement policies.
  localparam logic OP_WRITE    = 1'b1;
  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_SET_BITS    = 2'd1,
    CFG_WAY_LOG2    = 2'd2,
    CFG_POLICY      = 2'd3
  } cfg_reg_t;

  // Lookup sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MULT,
    S_MOD,
    S_SCAN,
    S_LAST,
    S_WRITE
  } sactl_state_t;

  // One access request.
  typedef struct packed {
    logic                 op;
    logic [ADDRESS_W-1:0] address;
  } sactl_in_t;

  // One lookup result.
  typedef struct packed {
    logic                  hit;
    logic [SET_NUM_W-1:0]  set_number;
    logic [WAY_USED_W-1:0] way_used;
    logic [HITS_W-1:0]     hits_so_far;
  } sactl_out_t;

endpackage

@@ rtl/set_assoc_cache_tag_lookup.sv @@
// Tag store of a set-associative cache with LRU or FIFO replacement. Each input beat carries
// one read or write address and yields exactly one result beat: hit flag, set number, the way
// that hit or was filled or replaced, and the running hit total. Tags, stamps, valid and dirty
// bits live in one synchronous memory of NUM_LINES entries with a single read port, so the ways
// of a set are read one per cycle, the number of ways being the configured associativity, capped
// at MAX_WAYS. A new access is taken only after the last one has written back. When NUM_LINES is
// not a power of two, the line number is first reduced modulo NUM_LINES one bit a cycle. After
// reset the memory is swept clear, one entry a cycle, before the first beat is taken;
// configuration writes are taken at any time and must only be issued while the block is idle.
`include "set_assoc_cache_tag_lookup_macros.svh"

module set_assoc_cache_tag_lookup #(
  parameter int ADDR_BITS  = sactl_pkg::ADDR_BITS_DEF,
  parameter int NUM_LINES  = sactl_pkg::NUM_LINES_DEF,
  parameter int MAX_WAYS   = sactl_pkg::MAX_WAYS_DEF,
  parameter int STAMP_BITS = sactl_pkg::STAMP_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sactl_pkg::sactl_in_t               in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sactl_pkg::sactl_out_t              out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sactl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sactl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sactl_pkg::*;

  localparam int LW   = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int WAYW = $clog2(MAX_WAYS + 1);
  localparam int WIW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int PW   = ADDR_BITS + WAYW;
  localparam int MCW  = $clog2(PW + 1);
  localparam bit LINES_POW2 = ((NUM_LINES & (NUM_LINES - 1)) == 0);
  localparam logic [LW-1:0] LINE_LAST = LW'(NUM_LINES - 1);
  localparam logic [LW:0]   LINES_N   = (LW + 1)'(NUM_LINES);

  typedef struct packed {
    logic                  valid;
    logic                  dirty;
    logic [ADDR_BITS-1:0]  tag;
    logic [STAMP_BITS-1:0] stamp;
  } line_word_t;

  // Configuration registers.
  logic [3:0] cfg_obits_r;
  logic [3:0] cfg_sbits_r;
  logic [1:0] cfg_wlog_r;
  logic       cfg_policy_r;

  // Sequencer and counters.
  sactl_state_t   state_r, state_nxt;
  logic [LW-1:0]  clr_idx_r;
  logic [31:0]    acc_cnt_r;
  logic [31:0]    hit_cnt_r;
  logic           out_valid_r;
  sactl_out_t     out_data_r;
  logic           finish;

  // Access being looked up.
  logic                 is_write_r;
  logic [ADDR_BITS-1:0] set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [PW-1:0]        prod_r;
  logic [LW-1:0]        rem_r;
  logic [MCW-1:0]       mod_cnt_r;
  logic [LW-1:0]        line_r;
  logic [WAYW-1:0]      issue_r;

  // Read-back evaluation and search results.
  logic                  eval_vld_r;
  logic [WIW-1:0]        eval_way_r;
  logic [LW-1:0]         eval_line_r;
  line_word_t            rd_data_r;
  logic                  hit_f_r, inv_f_r, min_f_r;
  logic [WIW-1:0]        hit_way_r, inv_way_r, min_way_r;
  logic [LW-1:0]         hit_line_r, inv_line_r, min_line_r;
  logic                  hit_dirty_r;
  logic [STAMP_BITS-1:0] hit_stamp_r;
  logic [STAMP_BITS-1:0] min_stamp_r;

  // Memory port.
  line_word_t mem [NUM_LINES];
  logic       wr_en;
  logic [LW-1:0] wr_addr;
  line_word_t wr_data;

  // Combinational helpers.
  logic [3:0]           ways_pow;
  logic [WAYW-1:0]      ways;
  logic [ADDR_BITS-1:0] addr_ext, block, set_in, tag_in;
  logic [PW-1:0]        prod;
  logic [LW:0]          rem_step, rem_sub;
  logic [WIW-1:0]       chosen_way;
  logic [LW-1:0]        chosen_line;
  logic [STAMP_BITS-1:0] cur_stamp;
  line_word_t           new_word;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_obits_r  <= 4'd1;
      cfg_sbits_r  <= 4'd0;
      cfg_wlog_r   <= 2'd0;
      cfg_policy_r <= POLICY_LRU;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OFFSET_BITS: cfg_obits_r  <= cfg_data;
        CFG_SET_BITS:    cfg_sbits_r  <= cfg_data;
        CFG_WAY_LOG2:    cfg_wlog_r   <= cfg_data[1:0];
        CFG_POLICY:      cfg_policy_r <= cfg_data[0];
        default:         cfg_policy_r <= cfg_policy_r;
      endcase
    end
  end

  // Associativity, capped at the number of ways the store is built for.
  assign ways_pow = 4'b0001 << cfg_wlog_r;
  assign ways = (32'(ways_pow) > MAX_WAYS) ? WAYW'(MAX_WAYS) : WAYW'(ways_pow);

  // Address split into set index and tag.
  assign addr_ext = ADDR_BITS'(in_data.address);
  assign block    = addr_ext >> cfg_obits_r;
  assign set_in   = block & ~({ADDR_BITS{1'b1}} << cfg_sbits_r);
  assign tag_in   = block >> cfg_sbits_r;

  // First line of the set, and one restoring step of the modulo reduction.
  assign prod     = PW'(set_r) * PW'(ways);
  assign rem_step = {rem_r, prod_r[PW-1]};
  assign rem_sub  = (rem_step >= LINES_N) ? (rem_step - LINES_N) : rem_step;

  // Victim choice: a hit first, then the first empty way, then the oldest stamp.
  assign cur_stamp = STAMP_BITS'(acc_cnt_r);
  always_comb begin
    if (hit_f_r) begin
      chosen_way  = hit_way_r;
      chosen_line = hit_line_r;
    end else if (inv_f_r) begin
      chosen_way  = inv_way_r;
      chosen_line = inv_line_r;
    end else begin
      chosen_way  = min_way_r;
      chosen_line = min_line_r;
    end
    new_word.valid = 1'b1;
    new_word.tag   = tag_r;
    if (hit_f_r) begin
      new_word.dirty = hit_dirty_r | is_write_r;
      new_word.stamp = (cfg_policy_r == POLICY_LRU) ? cur_stamp : hit_stamp_r;
    end else begin
      new_word.dirty = is_write_r;
      new_word.stamp = cur_stamp;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and memory write port.
  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    wr_addr   = chosen_line;
    wr_data   = new_word;
    finish    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        wr_data = '0;
        if (clr_idx_r == LINE_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_MULT;
      end
      S_MULT: begin
        state_nxt = LINES_POW2 ? S_SCAN : S_MOD;
      end
      S_MOD: begin
        if (mod_cnt_r == MCW'(PW - 1)) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (issue_r == (ways - 1'b1)) state_nxt = S_LAST;
      end
      S_LAST: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_r || out_ready) begin
          finish    = 1'b1;
          wr_en     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      acc_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      eval_vld_r  <= 1'b0;
    end else begin
      eval_vld_r <= (state_r == S_SCAN);
      if (state_r == S_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
      if (finish) begin
        acc_cnt_r   <= acc_cnt_r + 32'd1;
        hit_cnt_r   <= hit_cnt_r + 32'(hit_f_r);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r.hit         <= hit_f_r;
      out_data_r.set_number  <= SET_NUM_W'(set_r);
      out_data_r.way_used    <= WAY_USED_W'(chosen_way);
      out_data_r.hits_so_far <= hit_cnt_r + 32'(hit_f_r);
    end
  end

  // Address capture, line number and way scan.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      is_write_r <= (in_data.op == OP_WRITE);
      set_r      <= set_in;
      tag_r      <= tag_in;
    end
    case (state_r)
      S_MULT: begin
        prod_r    <= prod;
        rem_r     <= '0;
        mod_cnt_r <= '0;
        issue_r   <= '0;
        line_r    <= LW'(prod) & LINE_LAST;
      end
      S_MOD: begin
        prod_r    <= prod_r << 1;
        rem_r     <= LW'(rem_sub);
        mod_cnt_r <= mod_cnt_r + 1'b1;
        line_r    <= LW'(rem_sub);
      end
      S_SCAN: begin
        line_r      <= (line_r == LINE_LAST) ? '0 : (line_r + 1'b1);
        issue_r     <= issue_r + 1'b1;
        eval_way_r  <= WIW'(issue_r);
        eval_line_r <= line_r;
      end
      default: begin
        issue_r <= issue_r;
      end
    endcase
  end

  // Search over the words read back, one way per cycle.
  always_ff @(posedge clk) begin
    if (state_r == S_MULT) begin
      hit_f_r <= 1'b0;
      inv_f_r <= 1'b0;
      min_f_r <= 1'b0;
    end else if (eval_vld_r) begin
      if (rd_data_r.valid && (rd_data_r.tag == tag_r) && !hit_f_r) begin
        hit_f_r     <= 1'b1;
        hit_way_r   <= eval_way_r;
        hit_line_r  <= eval_line_r;
        hit_dirty_r <= rd_data_r.dirty;
        hit_stamp_r <= rd_data_r.stamp;
      end
      if (!rd_data_r.valid && !inv_f_r) begin
        inv_f_r    <= 1'b1;
        inv_way_r  <= eval_way_r;
        inv_line_r <= eval_line_r;
      end
      if (!min_f_r || (rd_data_r.stamp < min_stamp_r)) begin
        min_f_r     <= 1'b1;
        min_way_r   <= eval_way_r;
        min_line_r  <= eval_line_r;
        min_stamp_r <= rd_data_r.stamp;
      end
    end
  end

  // Line memory. The write-back of one access lands well before the next access reads,
  // so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[line_r];
  end

  `SACTL_ASSERT_IMP(a_no_accept_clear, clk, rst_n, state_r == S_CLEAR, !in_ready, "input beat taken during the clearing sweep")
  `SACTL_ASSERT_NXT(a_hit_count, clk, rst_n, finish && hit_f_r, hit_cnt_r == $past(hit_cnt_r) + 32'd1, "hit total did not advance on a hit")
  `SACTL_ASSERT_NXT(a_acc_hold, clk, rst_n, !finish, $stable(acc_cnt_r), "access counter moved without a finished access")
  `SACTL_ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == S_SCAN, issue_r < ways, "way scan ran past the associativity")
  `SACTL_ASSERT_IMP(a_out_rise, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_WRITE, "result raised outside write-back")

endmodule

@@ sim/set_assoc_cache_tag_lookup_tb.sv @@
module set_assoc_cache_tag_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sactl_pkg::*;

  localparam logic OP_READ     = 1'b0;
  localparam int   PHASES      = 8;
  localparam int   PHASE_ITEMS = 75;
  localparam int   SETTLE      = 20;
  localparam int   LONG_HOLD   = 300;
  localparam int   HOLD_AT     = 150;
  localparam int   POOL_SIZE   = 16;

  // One row of the directed sequence: either an access or a register write.
  typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    cfg_reg_t             reg_idx;
    logic [3:0]           value;
    logic                 op;
    logic [ADDRESS_W-1:0] addr;
    logic                 known;
    logic                 hit;
    logic [SET_NUM_W-1:0] set_number;
    logic [WAY_USED_W-1:0] way_used;
    logic [HITS_W-1:0]    hits_so_far;
  } dir_row_t;

  // A typed answer, where one is given, replaces the predicted one.
  typedef struct {
    bit         known;
    sactl_out_t want;
  } typed_note_t;

  localparam int DIR_ROWS = 39;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Reset settings: 2-byte blocks, one set, one way, LRU.
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0000, 1'b1, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0001, 1'b1, 1'b1, 8'd0, 3'd0, 32'd1},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 15'h7FFF, 1'b1, 1'b0, 8'd0, 3'd0, 32'd1},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 15'h7FFE, 1'b1, 1'b1, 8'd0, 3'd0, 32'd2},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0000, 1'b1, 1'b0, 8'd0, 3'd0, 32'd2},
    // Zero offset bits, four sets of two ways, FIFO.
    '{ROW_CONFIG, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_SET_BITS,    4'd2, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_WAY_LOG2,    4'd1, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_POLICY,      4'd1, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0004, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0008, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 15'h0001, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    // Same sets under LRU, so hits now refresh the stamp.
    '{ROW_CONFIG, CFG_POLICY,      4'd0, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0004, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h000C, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    // Offset of 14 bits, 8 set bits and the most ways.
    '{ROW_CONFIG, CFG_OFFSET_BITS, 4'd14, OP_READ, 15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_SET_BITS,    4'd8, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_WAY_LOG2,    4'd3, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 15'h7FFF, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h4000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    // Set index wider than the set number, with line numbers wrapping.
    '{ROW_CONFIG, CFG_OFFSET_BITS, 4'd1, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_SET_BITS,    4'd15, OP_READ, 15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 15'h7FFF, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h01FF, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h7FFE, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    // Fill a line with one way, then find it behind an empty way with two.
    '{ROW_CONFIG, CFG_SET_BITS,    4'd7, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_WAY_LOG2,    4'd0, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h00C6, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_WAY_LOG2,    4'd1, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h0062, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    // Offset as wide as the address: every address falls in one block.
    '{ROW_CONFIG, CFG_OFFSET_BITS, 4'd15, OP_READ, 15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_SET_BITS,    4'd0, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_CONFIG, CFG_WAY_LOG2,    4'd0, OP_READ,  15'h0000, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_READ,  15'h1234, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0},
    '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, OP_WRITE, 15'h7FFF, 1'b0, 1'b0, 8'd0, 3'd0, 32'd0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  sactl_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  sactl_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  set_assoc_cache_tag_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mirror of the tag store. The dirty bit never reaches the ports, so it is not kept.
  bit          line_ok    [NUM_LINES_DEF];
  int unsigned line_tag   [NUM_LINES_DEF];
  logic [31:0] line_stamp [NUM_LINES_DEF];
  logic [31:0] access_cnt = '0;
  logic [31:0] hit_cnt = '0;

  // Register mirror, updated on each accepted configuration beat.
  int unsigned cur_off = 1;
  int unsigned cur_sets = 0;
  int unsigned cur_wlog = 0;
  logic        cur_policy = POLICY_LRU;

  sactl_out_t  pending_results [$];
  typed_note_t typed_answers [$];

  int  fail_cnt = 0;
  int  taken_cnt = 0;
  int  result_cnt = 0;
  int  cfg_cnt = 0;
  bit  quiet = 1'b0;
  bit  long_hold_done = 1'b0;
  int  gap_pct = 20;

  function automatic int unsigned line_no(int unsigned set_idx, int unsigned way,
                                          int unsigned nways);
    return (set_idx * nways + way) % NUM_LINES_DEF;
  endfunction

  // Works out the lookup result for one address and updates the mirror as the block would.
  function automatic sactl_out_t predict_lookup(logic [ADDRESS_W-1:0] addr);
    int unsigned blk, set_idx, tg, nways, pick, ln, w;
    logic [31:0] oldest;
    bit          hit, found;
    sactl_out_t  r;
    blk     = 32'(addr) >> cur_off;
    set_idx = blk & ((32'd1 << cur_sets) - 1);
    tg      = blk >> cur_sets;
    nways   = 32'd1 << cur_wlog;
    if (nways > MAX_WAYS_DEF) nways = MAX_WAYS_DEF;
    hit   = 1'b0;
    found = 1'b0;
    pick  = 0;
    // A matching valid line in any way wins, even behind an empty way.
    for (w = 0; w < nways && !found; w++) begin
      ln = line_no(set_idx, w, nways);
      if (line_ok[ln] && line_tag[ln] == tg) begin
        pick  = w;
        found = 1'b1;
        hit   = 1'b1;
      end
    end
    for (w = 0; w < nways && !found; w++) begin
      if (!line_ok[line_no(set_idx, w, nways)]) begin
        pick  = w;
        found = 1'b1;
      end
    end
    // Every way full: the oldest stamp goes, the lowest way on a tie.
    if (!found) begin
      oldest = line_stamp[line_no(set_idx, 0, nways)];
      for (w = 1; w < nways; w++) begin
        ln = line_no(set_idx, w, nways);
        if (line_stamp[ln] < oldest) begin
          oldest = line_stamp[ln];
          pick   = w;
        end
      end
    end
    ln = line_no(set_idx, pick, nways);
    if (hit) begin
      if (cur_policy == POLICY_LRU) line_stamp[ln] = access_cnt;
      hit_cnt = hit_cnt + 32'd1;
    end else begin
      line_ok[ln]    = 1'b1;
      line_tag[ln]   = tg;
      line_stamp[ln] = access_cnt;
    end
    access_cnt = access_cnt + 32'd1;
    r.hit         = hit;
    r.set_number  = set_idx[SET_NUM_W-1:0];
    r.way_used    = pick[WAY_USED_W-1:0];
    r.hits_so_far = hit_cnt;
    return r;
  endfunction

  // Watches all three channels; results are checked against the oldest expectation.
  always @(posedge clk) begin : watch
    sactl_out_t  want;
    sactl_out_t  pred;
    typed_note_t note;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cfg_cnt++;
        case (cfg_reg_t'(cfg_index))
          CFG_OFFSET_BITS: cur_off = cfg_data;
          CFG_SET_BITS:    cur_sets = cfg_data;
          CFG_WAY_LOG2:    cur_wlog = cfg_data[1:0];
          CFG_POLICY:      cur_policy = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        result_cnt++;
        if (pending_results.size() == 0) begin
          $error("result beat arrived with nothing expected");
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
            fail_cnt++;
          end
          if (out_data.set_number !== want.set_number) begin
            $error("set_number: expected %0d, got %0d", want.set_number, out_data.set_number);
            fail_cnt++;
          end
          if (out_data.way_used !== want.way_used) begin
            $error("way_used: expected %0d, got %0d", want.way_used, out_data.way_used);
            fail_cnt++;
          end
          if (out_data.hits_so_far !== want.hits_so_far) begin
            $error("hits_so_far: expected %0d, got %0d", want.hits_so_far,
                   out_data.hits_so_far);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        taken_cnt++;
        pred = predict_lookup(in_data.address);
        note = typed_answers.pop_front();
        pending_results.push_back(note.known ? note.want : pred);
      end
    end
  end

  // Result side: short random stalls, one long hold-off while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && !long_hold_done && taken_cnt >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 30)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one access beat and holds it until taken, then maybe leaves a gap.
  task automatic offer(input logic op, input logic [ADDRESS_W-1:0] addr, input bit known,
                       input sactl_out_t want);
    typed_note_t note;
    sactl_in_t   beat;
    note.known   = known;
    note.want    = want;
    beat.op      = op;
    beat.address = addr;
    typed_answers.push_back(note);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stops offering and waits for every outstanding result plus the write-back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    dir_row_t          row;
    sactl_out_t        want;
    int unsigned       off, sets, wlog, tg, st;
    logic              pol;
    logic [ADDRESS_W-1:0] pool [POOL_SIZE];
    logic [ADDRESS_W-1:0] addr;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sequence.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_CONFIG) begin
        drain();
        write_reg(row.reg_idx, row.value);
      end else begin
        want.hit         = row.hit;
        want.set_number  = row.set_number;
        want.way_used    = row.way_used;
        want.hits_so_far = row.hits_so_far;
        offer(row.op, row.addr, row.known, want);
      end
    end

    // Random phases, each under its own settings, the first ones at the extremes.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin off = 14; sets = 8; wlog = 3; pol = POLICY_FIFO; end
        1: begin off = 1; sets = 0; wlog = 3; pol = POLICY_LRU; end
        2: begin off = 0; sets = 15; wlog = 0; pol = POLICY_FIFO; end
        default: begin
          off  = ($urandom_range(0, 9) == 0) ? 15 * $urandom_range(0, 1)
                                             : $urandom_range(1, 14);
          sets = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
          wlog = $urandom_range(0, 3);
          pol  = $urandom_range(0, 1);
        end
      endcase
      write_reg(CFG_OFFSET_BITS, off);
      write_reg(CFG_SET_BITS, sets);
      write_reg(CFG_WAY_LOG2, wlog);
      write_reg(CFG_POLICY, pol);

      // A few more tags than ways over a few sets, so lines get reused and evicted.
      for (int k = 0; k < POOL_SIZE; k++) begin
        tg = $urandom_range(0, (1 << wlog) + 2);
        st = $urandom_range(0, 3);
        pool[k] = ADDRESS_W'((tg << (off + sets)) | (st << off));
      end
      gap_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 40);
      quiet   = (p == PHASES - 1);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) addr = ADDRESS_W'($urandom);
        else addr = pool[$urandom_range(0, POOL_SIZE - 1)]
                    | ADDRESS_W'($urandom & ((32'd1 << off) - 1));
        offer($urandom_range(0, 1), addr, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Ran %0d accesses (%0d hits) with %0d register writes across %0d settings,",
             taken_cnt, hit_cnt, cfg_cnt, PHASES + 8);
    $display("including a long result stall and a pass with no idling on either side.");
    if (fail_cnt == 0) begin
      $display("set_assoc_cache_tag_lookup_tb OK");
    end else begin
      $display("set_assoc_cache_tag_lookup_tb NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #3_000_000;
    $error("run did not complete in time");
    $display("set_assoc_cache_tag_lookup_tb NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sactl_pkg.sv
rtl/set_assoc_cache_tag_lookup.sv
sim/set_assoc_cache_tag_lookup_tb.sv
